>>> src/mtat_pkg.sv
package mtat_pkg;

    // Fixed field widths of the register file and of the result item.
    localparam int HOME_W  = 14;
    localparam int MS_W    = 9;
    localparam int TOTAL_W = 29;
    localparam int TURNS_W = 14;
    localparam int STEP_W  = 30;
    localparam int QUAD_W  = 2;

    // Full steps per motor revolution and the width of full_steps * microsteps.
    localparam int FULL_STEPS = 200;
    localparam int K_W        = 17;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [MS_W-1:0] MS_RESET = 9'd16;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_HOME  = 1'b0;
    localparam logic REG_MICRO = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } state_t;

endpackage

>>> src/mtat_track.sv
module mtat_track #(
    parameter int ANGLE_BITS = 14,
    parameter int COUNT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               take,
    input  logic [ANGLE_BITS-1:0]              sample_angle,
    input  logic [mtat_pkg::HOME_W-1:0]        home_angle,
    output logic [COUNT_BITS+ANGLE_BITS-2:0]   total,
    output logic [COUNT_BITS-2:0]              turns,
    output logic [mtat_pkg::QUAD_W-1:0]        quadrant,
    output logic                               lost
);

    localparam logic [1:0] QSTEP_UP   = 2'd1;
    localparam logic [1:0] QSTEP_LOST = 2'd2;
    localparam logic [1:0] QSTEP_DOWN = 2'd3;

    logic [1:0]            last_q_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [ANGLE_BITS-1:0] home_a;
    logic [ANGLE_BITS-1:0] d;
    logic [1:0]            quad;
    logic [1:0]            qstep;
    logic [COUNT_BITS:0]   cx;
    logic [COUNT_BITS-2:0] t;
    logic [COUNT_BITS-2:0] m;
    logic                  c_pos;
    logic                  c_below;

    always_comb
    begin
        home_a = ANGLE_BITS'(home_angle);
        d      = sample_angle - home_a;
        quad   = d[ANGLE_BITS-1 -: 2];
        qstep  = quad - last_q_reg;
        lost   = (qstep == QSTEP_LOST);

        case (qstep)
            QSTEP_UP:   count_next = count_reg + COUNT_BITS'(1);
            QSTEP_DOWN: count_next = count_reg - COUNT_BITS'(1);
            default:    count_next = count_reg;
        endcase

        quadrant = lost ? last_q_reg : quad;

        // Whole turns: c/4 for c >= 0, (c+1)/4 for c < 0, truncated; the
        // negative case equals floor((c+4)/4).
        cx = {count_next[COUNT_BITS-1], count_next}
           + (count_next[COUNT_BITS-1] ? (COUNT_BITS+1)'(4) : (COUNT_BITS+1)'(0));
        t  = cx[COUNT_BITS:2];

        c_pos   = !count_next[COUNT_BITS-1] && (|count_next);
        c_below = count_next[COUNT_BITS-1] && !(&count_next);

        // The total is m * 2^ANGLE_BITS + d, where m folds the sign of the
        // in-turn angle into the turn offset.
        if (c_pos)
        begin
            m = t;
        end
        else if (c_below)
        begin
            m = t - (COUNT_BITS-1)'(1);
        end
        else
        begin
            m = {(COUNT_BITS-1){d[ANGLE_BITS-1]}};
        end

        total = {m, d};
        turns = t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_q_reg <= '0;
            count_reg  <= '0;
        end
        else if (take)
        begin
            last_q_reg <= quadrant;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/mtat_smul.sv
module mtat_smul #(
    parameter int ANGLE_BITS = 14,
    parameter int TOTAL_BITS = 29
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         ack,
    input  logic [TOTAL_BITS-1:0]        total,
    input  logic [mtat_pkg::MS_W-1:0]    microsteps,
    output logic                         done,
    output logic [mtat_pkg::STEP_W-1:0]  step
);

    localparam int KW  = mtat_pkg::K_W;
    localparam int SW  = mtat_pkg::STEP_W;
    localparam int CYC = ANGLE_BITS + SW;
    localparam int CW  = $clog2(CYC);

    logic [TOTAL_BITS-1:0] tot_sh_reg;
    logic [KW-1:0]         k_reg;
    logic [KW:0]           acc_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic                  nz_reg;
    logic                  carry_reg;
    logic                  neg_reg;
    logic [SW-1:0]         step_sh_reg;

    logic [KW-1:0]         k_load;
    logic [KW+1:0]         k_ext;
    logic [KW+1:0]         addend;
    logic [KW+1:0]         sum;
    logic                  pbit;
    logic                  cin;
    logic                  last_bit;

    always_comb
    begin
        k_load   = KW'(microsteps) * KW'(mtat_pkg::FULL_STEPS);
        k_ext    = {2'b00, k_reg};
        last_bit = (cnt_reg == CW'(TOTAL_BITS-1));

        // Signed serial-parallel multiply: the top bit of the total weighs
        // negative, so K is subtracted there instead of added.
        if (!tot_sh_reg[0])
        begin
            addend = '0;
        end
        else if (last_bit)
        begin
            addend = ~k_ext + (KW+2)'(1);
        end
        else
        begin
            addend = k_ext;
        end

        sum  = {acc_reg[KW], acc_reg} + addend;
        pbit = sum[0];

        // Truncation toward zero: a negative product with a nonzero
        // remainder gets one added to its floor quotient, rippled serially.
        cin = (cnt_reg == CW'(ANGLE_BITS)) ? (neg_reg & nz_reg) : carry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg && (cnt_reg == CW'(CYC-1)))
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
        else if (ack)
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            tot_sh_reg <= total;
            k_reg      <= k_load;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            nz_reg     <= 1'b0;
            neg_reg    <= total[TOTAL_BITS-1];
        end
        else if (run_reg)
        begin
            tot_sh_reg <= {1'b0, tot_sh_reg[TOTAL_BITS-1:1]};
            acc_reg    <= sum[KW+1:1];
            cnt_reg    <= cnt_reg + CW'(1);
            if (cnt_reg < CW'(ANGLE_BITS))
            begin
                nz_reg <= nz_reg | pbit;
            end
            else
            begin
                carry_reg   <= pbit & cin;
                step_sh_reg <= {pbit ^ cin, step_sh_reg[SW-1:1]};
            end
        end
    end

    assign done = done_reg;
    assign step = step_sh_reg;

endmodule

>>> src/multi_turn_angle_tracker.sv
// Multi-turn angle tracker. Each sample_angle item is an absolute sensor
// reading; the block finds its quadrant relative to home_angle, counts
// quadrant crossings in a wrapping signed counter of COUNT_BITS bits, and
// returns one result item per sample: the signed multi-turn angle in sensor
// counts, the whole turns, the motor position in microsteps (angle times
// 200 times microsteps over 2^ANGLE_BITS, truncated toward zero), the
// current quadrant, and a status bit that is set when a jump of exactly two
// quadrants was seen and ignored. The step position comes out of a
// bit-serial multiplier that walks one bit of the product per clock; each
// item passes through the accept cycle, the multiplier and the load of
// the result register. A new sample is taken as soon as the previous
// result has moved to the output register, even if that result has not
// yet been taken downstream. Registers home_angle (byte address 0) and
// microsteps (byte address 4) are written and read over the APB port and
// should only be changed while no item is in flight.
module multi_turn_angle_tracker #(
    parameter int ANGLE_BITS = 14,
    parameter int COUNT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mtat_pkg::ADDR_W-1:0]        paddr,
    input  logic [mtat_pkg::DATA_W-1:0]        pwdata,
    output logic [mtat_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,

    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [ANGLE_BITS-1:0]              sample_angle,

    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [mtat_pkg::TOTAL_W-1:0] total_angle,
    output logic signed [mtat_pkg::TURNS_W-1:0] turns,
    output logic signed [mtat_pkg::STEP_W-1:0]  step_position,
    output logic [mtat_pkg::QUAD_W-1:0]         current_quadrant,
    output logic                                status
);

    // Width of the full-precision total angle and of the turn count.
    localparam int TW     = COUNT_BITS - 1 + ANGLE_BITS;
    localparam int TURN_W = COUNT_BITS - 1;

    mtat_pkg::state_t state_reg;
    mtat_pkg::state_t state_next;

    logic [mtat_pkg::HOME_W-1:0] home_reg;
    logic [mtat_pkg::MS_W-1:0]   ms_reg;

    logic                        cfg_write;
    logic                        take;
    logic                        load_out;
    logic                        out_taken;

    logic [TW-1:0]               trk_total;
    logic [TURN_W-1:0]           trk_turns;
    logic [mtat_pkg::QUAD_W-1:0] trk_quad;
    logic                        trk_lost;

    logic                        mul_done;
    logic [mtat_pkg::STEP_W-1:0] mul_step;

    logic [63:0]                 total_ext;
    logic [31:0]                 turns_ext;

    // Side fields of the item in flight, held until its step position is done.
    logic [mtat_pkg::TOTAL_W-1:0] total_hold_reg;
    logic [mtat_pkg::TURNS_W-1:0] turns_hold_reg;
    logic [mtat_pkg::QUAD_W-1:0]  quad_hold_reg;
    logic                         status_hold_reg;

    // Output register.
    logic                         result_valid_reg;
    logic [mtat_pkg::TOTAL_W-1:0] total_angle_reg;
    logic [mtat_pkg::TURNS_W-1:0] turns_reg;
    logic [mtat_pkg::STEP_W-1:0]  step_position_reg;
    logic [mtat_pkg::QUAD_W-1:0]  current_quadrant_reg;
    logic                         status_reg;

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the access phase; the
    // port never waits.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_reg <= '0;
            ms_reg   <= mtat_pkg::MS_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                mtat_pkg::REG_HOME:  home_reg <= pwdata[mtat_pkg::HOME_W-1:0];
                mtat_pkg::REG_MICRO: ms_reg   <= pwdata[mtat_pkg::MS_W-1:0];
                default:             home_reg <= home_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            mtat_pkg::REG_HOME:  prdata = mtat_pkg::DATA_W'(home_reg);
            mtat_pkg::REG_MICRO: prdata = mtat_pkg::DATA_W'(ms_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Item control. A sample is taken only when no earlier item is in the
    // multiplier; the result moves to the output register as soon as that
    // register is empty or being emptied in the same cycle.
    // ------------------------------------------------------------------
    assign sample_stall = (state_reg != mtat_pkg::S_IDLE);
    assign take         = sample_valid && !sample_stall;
    assign out_taken    = result_valid_reg && !result_stall;
    assign load_out     = (state_reg == mtat_pkg::S_BUSY) && mul_done
                        && (!result_valid_reg || !result_stall);

    always_comb
    begin
        case (state_reg)
            mtat_pkg::S_IDLE: state_next = take ? mtat_pkg::S_BUSY : mtat_pkg::S_IDLE;
            mtat_pkg::S_BUSY: state_next = load_out ? mtat_pkg::S_IDLE : mtat_pkg::S_BUSY;
            default:          state_next = mtat_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtat_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Quadrant tracking, turn count and total angle, all settled within
    // the accept cycle.
    mtat_track #(
        .ANGLE_BITS (ANGLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .sample_angle (sample_angle),
        .home_angle   (home_reg),
        .total        (trk_total),
        .turns        (trk_turns),
        .quadrant     (trk_quad),
        .lost         (trk_lost)
    );

    // Bit-serial scaling of the total angle to microsteps.
    mtat_smul #(
        .ANGLE_BITS (ANGLE_BITS),
        .TOTAL_BITS (TW)
    ) u_smul (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (take),
        .ack        (load_out),
        .total      (trk_total),
        .microsteps (ms_reg),
        .done       (mul_done),
        .step       (mul_step)
    );

    // The reported fields are the full values wrapped to the field widths.
    assign total_ext = 64'(signed'(trk_total));
    assign turns_ext = 32'(signed'(trk_turns));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            total_hold_reg  <= total_ext[mtat_pkg::TOTAL_W-1:0];
            turns_hold_reg  <= turns_ext[mtat_pkg::TURNS_W-1:0];
            quad_hold_reg   <= trk_quad;
            status_hold_reg <= trk_lost;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (out_taken)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            total_angle_reg      <= total_hold_reg;
            turns_reg            <= turns_hold_reg;
            step_position_reg    <= mul_step;
            current_quadrant_reg <= quad_hold_reg;
            status_reg           <= status_hold_reg;
        end
    end

    assign result_valid     = result_valid_reg;
    assign total_angle      = signed'(total_angle_reg);
    assign turns            = signed'(turns_reg);
    assign step_position    = signed'(step_position_reg);
    assign current_quadrant = current_quadrant_reg;
    assign status           = status_reg;

endmodule

>>> tb/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_W = 14;
    localparam int COUNT_W = 16;
    localparam longint SPAN = 64'sd16384;

    // Cycles with no item moving on either channel before the run is called hung.
    // The long receiver hold-off below is the largest legal quiet stretch.
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 320;
    localparam int PHASE_ITEMS = 220;

    // One result item, laid out so that a whole item compares in one step.
    typedef struct packed {
        logic signed [mtat_pkg::TOTAL_W-1:0] total;
        logic signed [mtat_pkg::TURNS_W-1:0] turns;
        logic signed [mtat_pkg::STEP_W-1:0]  steps;
        logic [mtat_pkg::QUAD_W-1:0]         quad;
        logic                                lost;
    } track_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [mtat_pkg::ADDR_W-1:0] paddr = '0;
    logic [mtat_pkg::DATA_W-1:0] pwdata = '0;
    logic [mtat_pkg::DATA_W-1:0] prdata;
    logic pready;

    logic sample_valid = 1'b0;
    logic sample_stall;
    logic [ANGLE_W-1:0] sample_angle = '0;

    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [mtat_pkg::TOTAL_W-1:0] total_angle;
    logic signed [mtat_pkg::TURNS_W-1:0] turns;
    logic signed [mtat_pkg::STEP_W-1:0] step_position;
    logic [mtat_pkg::QUAD_W-1:0] current_quadrant;
    logic status;

    // Shadow of the block: its registers and its tracking state.
    logic [mtat_pkg::HOME_W-1:0] home_cfg = '0;
    logic [mtat_pkg::MS_W-1:0] micro_cfg = mtat_pkg::MS_RESET;
    logic [1:0] last_quad = 2'd0;
    logic signed [COUNT_W-1:0] quad_count = '0;

    logic [ANGLE_W-1:0] angles_to_send[$];
    track_result_t predicted_positions[$];

    // Handshake outcomes seen at the last rising edge, read by the drivers.
    bit sample_taken = 1'b0;
    bit result_taken = 1'b0;

    bit hold_req = 1'b0;
    int hold_left = 0;
    int send_gap = 0;
    int send_run = 0;
    int recv_wait = 0;
    int recv_run = 0;

    int idle_cycles = 0;
    int position_errors = 0;
    int results_checked = 0;
    int lost_results = 0;
    int settings_used = 1;
    int readbacks = 0;
    int count_low = 0;
    int count_high = 0;

    int sweep_pos = 0;
    int sweep_dir = 1;

    multi_turn_angle_tracker #(
        .ANGLE_BITS(ANGLE_W),
        .COUNT_BITS(COUNT_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_angle(sample_angle),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .total_angle(total_angle),
        .turns(turns),
        .step_position(step_position),
        .current_quadrant(current_quadrant),
        .status(status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Wait before the next item or the next take. Mostly random, but now and
    // then a run of back-to-back items so the block also sees full rate.
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // Advances the shadow tracker by one sample and returns the result item
    // that the block should produce for it.
    function automatic track_result_t advance_tracker(input logic [ANGLE_W-1:0] angle);
        logic [ANGLE_W-1:0] offset;
        logic [1:0] quad;
        logic [1:0] move;
        int count;
        int whole;
        longint delta;
        longint total;
        longint steps;
        track_result_t r;
        offset = angle - home_cfg;
        quad = offset[ANGLE_W-1 -: 2];
        move = quad - last_quad;
        r.lost = 1'b0;
        // A jump across two quadrants cannot be given a direction, so the
        // state stays where it was and the item is only flagged.
        if (move == 2'd2)
        begin
            r.lost = 1'b1;
        end
        else
        begin
            if (move == 2'd1)
            begin
                quad_count = quad_count + 1'b1;
            end
            else if (move == 2'd3)
            begin
                quad_count = quad_count - 1'b1;
            end
            last_quad = quad;
        end
        count = int'(quad_count);
        if (count < count_low)
        begin
            count_low = count;
        end
        if (count > count_high)
        begin
            count_high = count;
        end
        // Whole turns lean toward zero on both sides; minus one still counts
        // as the home turn.
        whole = (count >= 0) ? count / 4 : (count + 1) / 4;
        delta = longint'(offset);
        if (offset[ANGLE_W-1])
        begin
            delta = delta - SPAN;
        end
        // The angle within the turn is signed, so the turn it is added to
        // depends on which half of the circle the sample sits in.
        total = delta;
        if (count > 0)
        begin
            total = (delta >= 0) ? delta + whole * SPAN : delta + (whole + 1) * SPAN;
        end
        else if (count < -1)
        begin
            total = (delta < 0) ? delta + whole * SPAN : delta + (whole - 1) * SPAN;
        end
        steps = total * mtat_pkg::FULL_STEPS * longint'(micro_cfg) / SPAN;
        r.total = total[mtat_pkg::TOTAL_W-1:0];
        r.turns = whole[mtat_pkg::TURNS_W-1:0];
        r.steps = steps[mtat_pkg::STEP_W-1:0];
        r.quad = last_quad;
        return r;
    endfunction

    // Writes one register with a setup and an access cycle, then reads it
    // back through the same port and checks the value.
    task automatic write_register(input logic reg_sel,
                                  input logic [mtat_pkg::DATA_W-1:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_sel, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        if (reg_sel == mtat_pkg::REG_HOME)
        begin
            home_cfg = value[mtat_pkg::HOME_W-1:0];
        end
        else
        begin
            micro_cfg = value[mtat_pkg::MS_W-1:0];
        end
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        readbacks++;
        if (prdata !== value)
        begin
            position_errors++;
            if (position_errors <= 10)
            begin
                $display("register %0d reads back 0x%0h, expected 0x%0h",
                         reg_sel, prdata, value);
            end
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Blocks until every queued item has gone in and every result has come out.
    task automatic wait_drained();
        while (angles_to_send.size() != 0 || sample_valid || predicted_positions.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Registers only change with nothing in flight.
    task automatic retune(input logic [mtat_pkg::HOME_W-1:0] home,
                          input logic [mtat_pkg::MS_W-1:0] micro);
        wait_drained();
        repeat (8) @(negedge clk);
        write_register(mtat_pkg::REG_HOME, mtat_pkg::DATA_W'(home));
        write_register(mtat_pkg::REG_MICRO, mtat_pkg::DATA_W'(micro));
        settings_used++;
    endtask

    // Most items follow a shaft turning one way with steps below a quadrant,
    // so the quadrant count really walks; the direction flips now and then.
    // The rest are two-quadrant jumps and plain noise.
    task automatic queue_random_angles(input int count);
        int step;
        int pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0)
            begin
                sweep_dir = -sweep_dir;
            end
            if (pick < 85)
            begin
                step = sweep_dir * int'($urandom_range(0, 4095));
            end
            else if (pick < 93)
            begin
                step = 8192 + int'($urandom_range(0, 8)) - 4;
            end
            else
            begin
                step = int'($urandom_range(0, 16383));
            end
            sweep_pos = (sweep_pos + step) & 16383;
            angles_to_send.push_back(sweep_pos[ANGLE_W-1:0]);
        end
    endtask

    // Sender: one item offered at a time, held until taken, then a drawn gap.
    always @(negedge clk)
    begin
        if (rst_n && !(sample_valid && !sample_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                sample_valid <= 1'b0;
            end
            else if (angles_to_send.size() > 0)
            begin
                sample_angle <= angles_to_send.pop_front();
                sample_valid <= 1'b1;
                send_gap = draw_wait(send_run);
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls for a drawn number of cycles after each take, and for
    // one long stretch on request so the block backs up into its input.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (result_taken)
            begin
                recv_wait = draw_wait(recv_run);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Both handshakes are read at the rising edge, before the block's own
    // updates land. Accepted samples are predicted at once; accepted results
    // are compared with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        track_result_t got;
        track_result_t want;
        sample_taken = rst_n && sample_valid && !sample_stall;
        result_taken = rst_n && result_valid && !result_stall;
        if (sample_taken)
        begin
            predicted_positions.push_back(advance_tracker(sample_angle));
        end
        if (result_taken)
        begin
            got = {total_angle, turns, step_position, current_quadrant, status};
            if (predicted_positions.size() == 0)
            begin
                position_errors++;
                if (position_errors <= 10)
                begin
                    $display("result with nothing pending: total=%0d turns=%0d steps=%0d",
                             got.total, got.turns, got.steps);
                end
            end
            else
            begin
                want = predicted_positions.pop_front();
                results_checked++;
                if (want.lost)
                begin
                    lost_results++;
                end
                if (got !== want)
                begin
                    position_errors++;
                    if (position_errors <= 10)
                    begin
                        $display("result %0d: expected total=%0d turns=%0d steps=%0d quad=%0d lost=%0b",
                                 results_checked, want.total, want.turns, want.steps,
                                 want.quad, want.lost);
                        $display("    got      total=%0d turns=%0d steps=%0d quad=%0d lost=%0b",
                                 got.total, got.turns, got.steps, got.quad, got.lost);
                    end
                end
            end
        end
        if (!rst_n || sample_taken || result_taken)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
    end

    // Watchdog: a hang shows up as a long run of cycles with no traffic.
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("no item moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed walk under the reset registers (home 0, 16 microsteps):
        // both ends of the angle range, every quadrant boundary from both
        // sides, backward moves into negative counts including the minus one
        // count, both wraps between quadrants three and zero, lost jumps in
        // both pairings, and forward turns into positive counts.
        angles_to_send = '{
            14'd0, 14'd16383, 14'd12288, 14'd12287, 14'd8192, 14'd8191, 14'd4096,
            14'd4095, 14'd0, 14'd8192, 14'd4096, 14'd12288, 14'd8192, 14'd12288,
            14'd0, 14'd4096, 14'd8192, 14'd12288, 14'd16383, 14'd0, 14'd4095,
            14'd4096, 14'd12287, 14'd1, 14'h2AAA
        };
        wait_drained();

        // The top home angle first, with the long receiver hold-off
        // in the first random phase.
        retune(14'd16383, 9'd256);
        @(posedge clk);
        hold_req = 1'b1;
        queue_random_angles(PHASE_ITEMS);

        retune(mtat_pkg::HOME_W'($urandom_range(0, 16383)), 9'd1);
        queue_random_angles(PHASE_ITEMS);

        // Zero microsteps pins the step position at zero.
        retune(14'd8192, 9'd0);
        queue_random_angles(PHASE_ITEMS);

        // The top of the 9-bit register is taken as written.
        retune(mtat_pkg::HOME_W'($urandom_range(0, 16383)), 9'd511);
        queue_random_angles(PHASE_ITEMS);

        retune(14'd0, mtat_pkg::MS_W'($urandom_range(1, 256)));
        queue_random_angles(PHASE_ITEMS);

        retune(14'd1, mtat_pkg::MS_W'($urandom_range(1, 256)));
        queue_random_angles(PHASE_ITEMS);

        wait_drained();
        repeat (60) @(posedge clk);

        $display("Checked %0d results under %0d register settings, %0d flagged as lost.",
                 results_checked, settings_used, lost_results);
        $display("Quadrant count spanned %0d to %0d; %0d register readbacks checked.",
                 count_low, count_high, readbacks);
        if (position_errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("%0d mismatches", position_errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
